// ===== rtl/tod_pkg.sv =====
// ----------------------------------------------------------------------------
// tod_pkg
// Types, constants and helpers shared by the transient onset detector.
// ----------------------------------------------------------------------------
package tod_pkg;

    localparam int MAG_BITS     = 16;
    localparam int TIME_BITS    = 32;
    localparam int CFG_BITS     = 16;
    localparam int DUR_MS_BITS  = 23;
    localparam int REASON_BITS  = 2;
    localparam int NUM_REGS     = 7;
    localparam int CFG_IDX_BITS = 3;
    localparam int US_PER_MS    = 1000;

    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam int                  DIV_MAGIC_BITS = 29;
    localparam logic [DIV_MAGIC_BITS-1:0] DIV_MAGIC = 29'd274877907;
    localparam int                  DIV_SHIFT      = 38;
    localparam int                  PROD_BITS      = TIME_BITS + DIV_MAGIC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DURATION = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DURATION = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_STRENGTH = 3'd6;

    localparam logic [CFG_BITS-1:0] MAX_DURATION_RESET = 16'hFFFF;

    localparam logic [REASON_BITS-1:0] ONSET_NONE        = 2'd0;
    localparam logic [REASON_BITS-1:0] ONSET_BELOW       = 2'd1;
    localparam logic [REASON_BITS-1:0] ONSET_PEAK_ACTIVE = 2'd2;
    localparam logic [REASON_BITS-1:0] ONSET_COOLDOWN    = 2'd3;

    localparam logic [REASON_BITS-1:0] TRANS_NONE      = 2'd0;
    localparam logic [REASON_BITS-1:0] TRANS_TOO_SHORT = 2'd1;
    localparam logic [REASON_BITS-1:0] TRANS_TOO_LONG  = 2'd2;
    localparam logic [REASON_BITS-1:0] TRANS_WEAK      = 2'd3;

    typedef struct packed {
        logic [MAG_BITS-1:0]  magnitude;
        logic [TIME_BITS-1:0] sample_time_us;
    } sample_t;

    typedef struct packed {
        logic                   onset_detected;
        logic [MAG_BITS-1:0]    onset_strength;
        logic                   transient_detected;
        logic [MAG_BITS-1:0]    transient_strength;
        logic [DUR_MS_BITS-1:0] transient_duration_ms;
        logic [REASON_BITS-1:0] onset_reason;
        logic [REASON_BITS-1:0] transient_reason;
        logic [DUR_MS_BITS-1:0] rejected_duration_ms;
        logic [MAG_BITS-1:0]    rejected_strength;
        logic                   peak_open;
        logic [TIME_BITS-1:0]   onset_reject_count;
        logic [TIME_BITS-1:0]   transient_reject_count;
    } result_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] attack_threshold;
        logic [CFG_BITS-1:0] release_threshold;
        logic [CFG_BITS-1:0] cooldown_ms;
        logic [CFG_BITS-1:0] release_debounce_ms;
        logic [CFG_BITS-1:0] min_duration_ms;
        logic [CFG_BITS-1:0] max_duration_ms;
        logic [CFG_BITS-1:0] min_peak_strength;
    } cfg_t;

    typedef struct packed {
        logic                   onset_detected;
        logic [MAG_BITS-1:0]    onset_strength;
        logic                   transient_detected;
        logic [MAG_BITS-1:0]    transient_strength;
        logic [REASON_BITS-1:0] onset_reason;
        logic [REASON_BITS-1:0] transient_reason;
        logic [MAG_BITS-1:0]    rejected_strength;
        logic                   peak_open;
        logic [TIME_BITS-1:0]   onset_reject_count;
        logic [TIME_BITS-1:0]   transient_reject_count;
        logic                   closed;
        logic [TIME_BITS-1:0]   dur_us;
    } core_word_t;

    function automatic logic [TIME_BITS-1:0] ms_to_us(input logic [CFG_BITS-1:0] ms);
        return TIME_BITS'(ms) * TIME_BITS'(US_PER_MS);
    endfunction

endpackage

// ===== rtl/tod_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tod_cfg_regs
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tod_cfg_regs
    import tod_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_threshold    <= '0;
            cfg_reg.release_threshold   <= '0;
            cfg_reg.cooldown_ms         <= '0;
            cfg_reg.release_debounce_ms <= '0;
            cfg_reg.min_duration_ms     <= '0;
            cfg_reg.max_duration_ms     <= MAX_DURATION_RESET;
            cfg_reg.min_peak_strength   <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ATTACK:       cfg_reg.attack_threshold    <= cfg_wdata;
                REG_RELEASE:      cfg_reg.release_threshold   <= cfg_wdata;
                REG_COOLDOWN:     cfg_reg.cooldown_ms         <= cfg_wdata;
                REG_DEBOUNCE:     cfg_reg.release_debounce_ms <= cfg_wdata;
                REG_MIN_DURATION: cfg_reg.min_duration_ms     <= cfg_wdata;
                REG_MAX_DURATION: cfg_reg.max_duration_ms     <= cfg_wdata;
                REG_MIN_STRENGTH: cfg_reg.min_peak_strength   <= cfg_wdata;
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/tod_core.sv =====
// ----------------------------------------------------------------------------
// tod_core
// Input register, onset and release rules on the peak state, and the
// registered per-word decision handed to the reporting stage.
// ----------------------------------------------------------------------------
module tod_core
    import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    input  sample_t    sample,
    input  cfg_t       cfg,
    output logic       word_valid,
    input  logic       word_ready,
    output core_word_t word
);

    logic                   s0_valid_reg;
    sample_t                s0_data_reg;
    logic                   s1_valid_reg;
    core_word_t             s1_word_reg;

    logic                   open_reg;
    logic [TIME_BITS-1:0]   start_reg;
    logic                   pend_reg;
    logic [TIME_BITS-1:0]   rstart_reg;
    logic [MAG_BITS-1:0]    max_reg;
    logic [TIME_BITS-1:0]   last_onset_reg;
    logic [REASON_BITS-1:0] trans_reason_reg;
    logic [MAG_BITS-1:0]    rej_str_reg;
    logic [TIME_BITS-1:0]   onset_rej_reg;
    logic [TIME_BITS-1:0]   trans_rej_reg;

    logic                   open_next;
    logic [TIME_BITS-1:0]   start_next;
    logic                   pend_next;
    logic [TIME_BITS-1:0]   rstart_next;
    logic [MAG_BITS-1:0]    max_next;
    logic [TIME_BITS-1:0]   last_onset_next;
    logic [REASON_BITS-1:0] trans_reason_next;
    logic [MAG_BITS-1:0]    rej_str_next;
    logic [TIME_BITS-1:0]   onset_rej_next;
    logic [TIME_BITS-1:0]   trans_rej_next;
    core_word_t             s1_word_next;

    logic                   s1_ready;
    logic                   s0_adv;

    logic [MAG_BITS-1:0]    mag;
    logic [TIME_BITS-1:0]   now;
    logic                   above_attack;
    logic                   above_release;
    logic                   cooled;
    logic                   onset;
    logic                   open_a;
    logic [MAG_BITS-1:0]    max_a;
    logic [MAG_BITS-1:0]    max_b;
    logic                   pend_start;
    logic                   pend_b;
    logic [TIME_BITS-1:0]   rel_elapsed;
    logic [TIME_BITS-1:0]   dur_us;
    logic                   close;
    logic                   too_short;
    logic                   too_long;
    logic                   too_weak;
    logic                   accepted;
    logic [REASON_BITS-1:0] onset_reason;

    assign s1_ready     = !s1_valid_reg || word_ready;
    assign s0_adv       = s0_valid_reg && s1_ready;
    assign sample_ready = !s0_valid_reg || s1_ready;

    assign mag = s0_data_reg.magnitude;
    assign now = s0_data_reg.sample_time_us;

    always_comb
    begin
        above_attack  = mag > cfg.attack_threshold;
        above_release = mag > cfg.release_threshold;
        cooled        = (now - last_onset_reg) >= ms_to_us(cfg.cooldown_ms);
        onset         = above_attack && !open_reg && cooled;

        // onset rule
        open_a = open_reg || onset;
        max_a  = onset ? mag : max_reg;
        dur_us = onset ? '0 : now - start_reg;

        if (onset)
            onset_reason = ONSET_NONE;
        else if (!above_attack)
            onset_reason = ONSET_BELOW;
        else if (open_reg)
            onset_reason = ONSET_PEAK_ACTIVE;
        else
            onset_reason = ONSET_COOLDOWN;

        // release rule
        max_b       = (open_a && mag > max_a) ? mag : max_a;
        pend_start  = open_a && !above_release && !pend_reg;
        pend_b      = open_a ? !above_release : pend_reg;
        rel_elapsed = pend_start ? '0 : now - rstart_reg;
        close       = open_a && pend_b && rel_elapsed >= ms_to_us(cfg.release_debounce_ms);

        too_short = dur_us < ms_to_us(cfg.min_duration_ms);
        too_long  = dur_us > ms_to_us(cfg.max_duration_ms);
        too_weak  = max_b < cfg.min_peak_strength;
        accepted  = !too_short && !too_long && !too_weak;

        last_onset_next = onset ? now : last_onset_reg;
        onset_rej_next  = onset_rej_reg + TIME_BITS'(!onset && above_attack);

        if (close)
        begin
            open_next      = 1'b0;
            start_next     = '0;
            pend_next      = 1'b0;
            rstart_next    = '0;
            max_next       = '0;
            trans_rej_next = trans_rej_reg + TIME_BITS'(!accepted);
            rej_str_next   = accepted ? '0 : max_b;
            if (accepted)
                trans_reason_next = TRANS_NONE;
            else if (too_short)
                trans_reason_next = TRANS_TOO_SHORT;
            else if (too_long)
                trans_reason_next = TRANS_TOO_LONG;
            else
                trans_reason_next = TRANS_WEAK;
        end
        else
        begin
            open_next         = open_a;
            start_next        = onset ? now : start_reg;
            pend_next         = pend_b;
            rstart_next       = pend_start ? now : rstart_reg;
            max_next          = max_b;
            trans_rej_next    = trans_rej_reg;
            rej_str_next      = rej_str_reg;
            trans_reason_next = trans_reason_reg;
        end

        s1_word_next.onset_detected         = onset;
        s1_word_next.onset_strength         = onset ? mag : '0;
        s1_word_next.transient_detected     = close && accepted;
        s1_word_next.transient_strength     = (close && accepted) ? max_b : '0;
        s1_word_next.onset_reason           = onset_reason;
        s1_word_next.transient_reason       = trans_reason_next;
        s1_word_next.rejected_strength      = rej_str_next;
        s1_word_next.peak_open              = open_next;
        s1_word_next.onset_reject_count     = onset_rej_next;
        s1_word_next.transient_reject_count = trans_rej_next;
        s1_word_next.closed                 = close;
        s1_word_next.dur_us                 = dur_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            open_reg         <= 1'b0;
            start_reg        <= '0;
            pend_reg         <= 1'b0;
            rstart_reg       <= '0;
            max_reg          <= '0;
            last_onset_reg   <= '0;
            trans_reason_reg <= TRANS_NONE;
            rej_str_reg      <= '0;
            onset_rej_reg    <= '0;
            trans_rej_reg    <= '0;
        end
        else
        begin
            if (sample_ready)
                s0_valid_reg <= sample_valid;
            if (s1_ready)
                s1_valid_reg <= s0_valid_reg;
            if (s0_adv)
            begin
                open_reg         <= open_next;
                start_reg        <= start_next;
                pend_reg         <= pend_next;
                rstart_reg       <= rstart_next;
                max_reg          <= max_next;
                last_onset_reg   <= last_onset_next;
                trans_reason_reg <= trans_reason_next;
                rej_str_reg      <= rej_str_next;
                onset_rej_reg    <= onset_rej_next;
                trans_rej_reg    <= trans_rej_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
            s0_data_reg <= sample;
        if (s0_adv)
            s1_word_reg <= s1_word_next;
    end

    assign word_valid = s1_valid_reg;
    assign word       = s1_word_reg;

endmodule

// ===== rtl/tod_report.sv =====
// ----------------------------------------------------------------------------
// tod_report
// Converts closed peak durations to milliseconds by reciprocal multiply,
// keeps the held accepted and rejected durations, and drives the result.
// ----------------------------------------------------------------------------
module tod_report
    import tod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       word_valid,
    output logic       word_ready,
    input  core_word_t word,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    logic                   p_valid_reg;
    core_word_t             p_word_reg;
    logic [PROD_BITS-1:0]   p_prod_reg;
    logic [PROD_BITS-1:0]   p_prod_next;
    logic                   o_valid_reg;
    result_t                o_word_reg;
    result_t                o_word_next;
    logic [DUR_MS_BITS-1:0] acc_ms_reg;
    logic [DUR_MS_BITS-1:0] acc_ms_next;
    logic [DUR_MS_BITS-1:0] rej_ms_reg;
    logic [DUR_MS_BITS-1:0] rej_ms_next;

    logic                   o_ready;
    logic                   p_ready;
    logic                   p_adv;
    logic [DUR_MS_BITS-1:0] dur_ms;

    assign o_ready    = !o_valid_reg || result_ready;
    assign p_ready    = !p_valid_reg || o_ready;
    assign p_adv      = p_valid_reg && o_ready;
    assign word_ready = p_ready;

    assign p_prod_next = PROD_BITS'(word.dur_us) * PROD_BITS'(DIV_MAGIC);
    assign dur_ms      = p_prod_reg[DIV_SHIFT +: DUR_MS_BITS];

    always_comb
    begin
        acc_ms_next = acc_ms_reg;
        rej_ms_next = rej_ms_reg;
        if (p_word_reg.closed)
        begin
            if (p_word_reg.transient_detected)
            begin
                acc_ms_next = dur_ms;
                rej_ms_next = '0;
            end
            else
                rej_ms_next = dur_ms;
        end

        o_word_next.onset_detected         = p_word_reg.onset_detected;
        o_word_next.onset_strength         = p_word_reg.onset_strength;
        o_word_next.transient_detected     = p_word_reg.transient_detected;
        o_word_next.transient_strength     = p_word_reg.transient_strength;
        o_word_next.transient_duration_ms  = acc_ms_next;
        o_word_next.onset_reason           = p_word_reg.onset_reason;
        o_word_next.transient_reason       = p_word_reg.transient_reason;
        o_word_next.rejected_duration_ms   = rej_ms_next;
        o_word_next.rejected_strength      = p_word_reg.rejected_strength;
        o_word_next.peak_open              = p_word_reg.peak_open;
        o_word_next.onset_reject_count     = p_word_reg.onset_reject_count;
        o_word_next.transient_reject_count = p_word_reg.transient_reject_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            acc_ms_reg  <= '0;
            rej_ms_reg  <= '0;
        end
        else
        begin
            if (p_ready)
                p_valid_reg <= word_valid;
            if (o_ready)
                o_valid_reg <= p_valid_reg;
            if (p_adv)
            begin
                acc_ms_reg <= acc_ms_next;
                rej_ms_reg <= rej_ms_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && word_valid)
        begin
            p_word_reg <= word;
            p_prod_reg <= p_prod_next;
        end
        if (p_adv)
            o_word_reg <= o_word_next;
    end

    assign result_valid = o_valid_reg;
    assign result       = o_word_reg;

endmodule

// ===== rtl/transient_onset_detector.sv =====
// ----------------------------------------------------------------------------
// transient_onset_detector
// Hysteresis onset detector with release debounce on timestamped samples.
//
// Usage: each sample word (magnitude, microsecond timestamp) enters on the
// sample channel and yields exactly one result word on the result channel,
// in order. Both channels use valid/ready; a word moves when both are high.
// A word passes through four register stages on its way to result_valid:
// input register, peak state update, duration multiply, result register.
// Throughput is one word per cycle unless the receiver stalls; the peak
// state loop has no bubble, so consecutive samples may follow back to back.
// When the receiver stalls, words collect in the internal stages and
// sample_ready drops only once all four stages are full.
// The user is to write configuration (cfg_wen/cfg_index/cfg_wdata) while
// the block is idle (unenforced); indexes past the last register are ignored.
// Reset clears the peak state, counters and held reasons and durations,
// and loads the register defaults (max duration 65535 ms, others zero).
// ----------------------------------------------------------------------------
module transient_onset_detector
    import tod_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  sample_t                 sample,
    output logic                    result_valid,
    input  logic                    result_ready,
    output result_t                 result,
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata
);

    cfg_t       cfg;
    logic       core_valid;
    logic       core_ready;
    core_word_t core_word;

    tod_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tod_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .cfg          (cfg),
        .word_valid   (core_valid),
        .word_ready   (core_ready),
        .word         (core_word)
    );

    tod_report u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_valid   (core_valid),
        .word_ready   (core_ready),
        .word         (core_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // an accepted transient clears the rejection record and closes the peak
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.transient_detected |->
            !result.peak_open && result.transient_reason == TRANS_NONE &&
            result.rejected_strength == '0 && result.rejected_duration_ms == '0)
    else $error("accepted transient with stale rejection state");

    // an onset needs a magnitude above the threshold, so it is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.onset_detected |->
            result.onset_strength != '0 && result.onset_reason == ONSET_NONE)
    else $error("onset reported with zero strength or a refusal reason");

    // only a closed peak can be reported as a transient
    assert property (@(posedge clk) disable iff (!rst_n)
        core_valid && core_word.transient_detected |-> core_word.closed)
    else $error("transient flagged without a peak close");

endmodule
